FILE: hw/rtl/mhs_pkg.sv
// Shared types and constants for the Metropolis-Hastings sampler.
// Holds the sequencer state type, register indexes, mixture constants and the 2^(-k/16) table.
// No dependencies.
package mhs_pkg;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_STEP   = 12'b000000000010,
    S_PROP   = 12'b000000000100,
    S_SQ     = 12'b000000001000,
    S_DIVI   = 12'b000000010000,
    S_LOG    = 12'b000000100000,
    S_EXP    = 12'b000001000000,
    S_INTERP = 12'b000010000000,
    S_ACCMUL = 12'b000100000000,
    S_DECIDE = 12'b001000000000,
    S_HREAD  = 12'b010000000000,
    S_HWRITE = 12'b100000000000
  } state_e;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;

  localparam logic [15:0] START_RESET = 16'd1792;
  localparam logic [15:0] SCALE_RESET = 16'd768;

  localparam logic [16:0] MEAN_A = -17'sd1280;
  localparam logic [16:0] MEAN_B = -17'sd3840;
  localparam logic [5:0]  TVAR_A = 6'd50;
  localparam logic [5:0]  TVAR_B = 6'd18;
  // ceil(2^30 / sigma^2), applied to half the square.
  localparam logic [26:0] RECIP_A = 27'd42949673;
  localparam logic [26:0] RECIP_B = 27'd119304648;
  localparam logic [17:0] LOG2E_Q16 = 18'd94548;

  function automatic logic [16:0] pow2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62758;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/mhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/metropolis_hastings_sampler_unit.sv
// Metropolis-Hastings random-walk sampler with a histogram of visited positions.
// Depends on mhs_pkg and mhs_ram.
//
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | normal_draw_i, uniform_draw_i
// out     | output    | out_valid_o / out_stall_i | new_position_o, accepted_o, bin_index_o,
//         |           |                           | bin_count_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A request passes the accepting cycle, S_STEP and S_PROP for the proposal, S_SQ to S_INTERP per
// mixture term on the shared multiplier, then S_ACCMUL to S_HWRITE for decision and histogram.
// A term ends in S_DIVI when its square alone rounds it to zero, in S_EXP when the exponent is
// past 16 and in S_INTERP otherwise. After reset and after a start_position write the start
// density is evaluated before a request is taken. The histogram valid bits clear at reset.
// A finished result waits in the output register; the next one stalls only on a full register.
module metropolis_hastings_sampler_unit #(
  parameter int HIST_BINS  = 64,
  parameter int COUNT_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] normal_draw_i,
  input  logic [15:0] uniform_draw_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] new_position_o,
  output logic        accepted_o,
  output logic [7:0]  bin_index_o,
  output logic [19:0] bin_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int IDX_W = $clog2(HIST_BINS);
  localparam logic [10:0] HALF_BINS = 11'(HIST_BINS / 2);
  localparam logic [10:0] LAST_BIN = 11'(HIST_BINS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  mhs_pkg::state_e state_q, state_d;

  logic [15:0] scale_q;
  logic [15:0] pos_q;
  logic [15:0] x_q;
  logic [17:0] cd_q;
  logic [17:0] dens_q;
  logic        comp_q;
  logic        load_q;
  logic [15:0] nd_q;
  logic [15:0] u_q;
  logic [51:0] p_q;
  logic [15:0] f_q;
  logic [4:0]  n_q;
  logic        acc_q;
  logic [HIST_BINS-1:0] valid_q;
  logic        out_valid_q;
  logic [15:0] out_pos_q;
  logic        out_acc_q;
  logic [7:0]  out_bin_q;
  logic [19:0] out_cnt_q;

  // Shared multiplier operands.
  logic [26:0] mul_a;
  logic [24:0] mul_b;

  logic        cfg_we;
  logic        in_acc;
  logic [16:0] mean;
  logic [5:0]  tvar;
  logic [16:0] pos_diff;
  logic [16:0] adist;
  logic [16:0] nd_abs;
  logic [32:0] sprod;
  logic [21:0] prop;
  logic [15:0] prop_sat;
  logic [20:0] yv;
  logic [3:0]  kf;
  logic [16:0] tab_k;
  logic [16:0] tab_k1;
  logic [16:0] interp;
  logic        term_done;
  logic [16:0] term_val;
  logic [17:0] dens_next;
  logic        accept_prop;
  logic [16:0] pos_mag;
  logic [8:0]  rnd_mag;
  logic [10:0] rnd_s;
  logic [10:0] bin_s;
  logic [IDX_W-1:0] bin_idx;
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] cnt_old;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [31:0] cnt_ext;
  logic        hist_we;
  logic        out_busy;

  // A configuration write takes priority over a request in the same cycle.
  assign in_stall_o  = (state_q != mhs_pkg::S_IDLE) || cfg_we;
  assign cfg_ready_o = (state_q == mhs_pkg::S_IDLE) && !out_valid_q;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_busy    = out_valid_q && out_stall_i;

  assign mean     = comp_q ? mhs_pkg::MEAN_B : mhs_pkg::MEAN_A;
  assign tvar     = comp_q ? mhs_pkg::TVAR_B : mhs_pkg::TVAR_A;
  assign pos_diff = {x_q[15], x_q} - mean;
  assign adist    = pos_diff[16] ? (17'd0 - pos_diff) : pos_diff;
  assign nd_abs   = nd_q[15] ? (17'd0 - {nd_q[15], nd_q}) : {1'b0, nd_q};

  // Proposal step: floor(scale * normal / 4096), then a saturating add.
  assign sprod = nd_q[15] ? (33'd0 - {1'b0, p_q[31:0]}) : {1'b0, p_q[31:0]};
  assign prop  = {{6{pos_q[15]}}, pos_q} + {sprod[32], sprod[32:12]};
  always_comb begin
    if (!prop[21] && (prop[20:15] != 6'd0)) begin
      prop_sat = 16'h7fff;
    end else if (prop[21] && (prop[20:15] != 6'h3f)) begin
      prop_sat = 16'h8000;
    end else begin
      prop_sat = prop[15:0];
    end
  end

  assign yv     = p_q[36:16];
  assign kf     = (state_q == mhs_pkg::S_EXP) ? yv[15:12] : f_q[15:12];
  assign tab_k  = mhs_pkg::pow2_tab({1'b0, kf});
  assign tab_k1 = mhs_pkg::pow2_tab(5'({1'b0, kf}) + 5'd1);
  assign interp = tab_k - {5'd0, p_q[23:12]};

  always_comb begin
    term_done = 1'b0;
    term_val  = 17'd0;
    case (state_q)
      mhs_pkg::S_DIVI: begin
        term_done = (p_q[30:20] >= {5'd0, tvar});
      end
      mhs_pkg::S_EXP: begin
        term_done = (yv[20:16] > 5'd16);
      end
      mhs_pkg::S_INTERP: begin
        term_done = 1'b1;
        term_val  = interp >> n_q;
      end
      default: begin
        term_done = 1'b0;
      end
    endcase
  end
  assign dens_next = dens_q + {1'b0, term_val};

  // Division by 2*sigma^2: the halved square times ceil(2^30 / sigma^2), taken from bit 30.
  // Below the early exit the halved square is under 2^25, where this quotient is exact.
  always_comb begin
    case (state_q)
      mhs_pkg::S_STEP: begin
        mul_a = {11'd0, scale_q};
        mul_b = {8'd0, nd_abs};
      end
      mhs_pkg::S_SQ: begin
        mul_a = {10'd0, adist};
        mul_b = {8'd0, adist};
      end
      mhs_pkg::S_DIVI: begin
        mul_a = comp_q ? mhs_pkg::RECIP_B : mhs_pkg::RECIP_A;
        mul_b = p_q[25:1];
      end
      mhs_pkg::S_LOG: begin
        mul_a = {7'd0, p_q[49:30]};
        mul_b = {7'd0, mhs_pkg::LOG2E_Q16};
      end
      mhs_pkg::S_EXP: begin
        mul_a = {10'd0, tab_k - tab_k1};
        mul_b = {13'd0, yv[11:0]};
      end
      mhs_pkg::S_ACCMUL: begin
        mul_a = {11'd0, u_q};
        mul_b = {7'd0, cd_q};
      end
      default: begin
        mul_a = 27'd0;
        mul_b = 25'd0;
      end
    endcase
  end

  assign accept_prop = ({dens_q, 16'd0} >= p_q[33:0]);

  // Histogram bin of the rounded position, halves away from zero.
  assign pos_mag = pos_q[15] ? (17'd0 - {1'b1, pos_q}) : {1'b0, pos_q};
  assign rnd_mag = 9'((pos_mag + 17'd128) >> 8);
  assign rnd_s   = pos_q[15] ? (11'd0 - {2'd0, rnd_mag}) : {2'd0, rnd_mag};
  assign bin_s   = rnd_s + HALF_BINS;
  always_comb begin
    if (bin_s[10]) begin
      bin_idx = '0;
    end else if (bin_s > LAST_BIN) begin
      bin_idx = LAST_BIN[IDX_W-1:0];
    end else begin
      bin_idx = bin_s[IDX_W-1:0];
    end
  end

  assign cnt_old = valid_q[bin_idx] ? rdata : '0;
  assign cnt_new = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + 1'b1;
  assign cnt_ext = 32'(cnt_new);
  assign hist_we = (state_q == mhs_pkg::S_HWRITE) && !out_busy;

  mhs_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(HIST_BINS)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(bin_idx),
    .wdata_i(cnt_new),
    .raddr_i(bin_idx),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      mhs_pkg::S_IDLE: begin
        if (cfg_we && (cfg_index_i == mhs_pkg::REG_START)) begin
          state_d = mhs_pkg::S_SQ;
        end else if (in_acc) begin
          state_d = mhs_pkg::S_STEP;
        end
      end
      mhs_pkg::S_STEP:   state_d = mhs_pkg::S_PROP;
      mhs_pkg::S_PROP:   state_d = mhs_pkg::S_SQ;
      mhs_pkg::S_SQ:     state_d = mhs_pkg::S_DIVI;
      mhs_pkg::S_DIVI:   state_d = mhs_pkg::S_LOG;
      mhs_pkg::S_LOG:    state_d = mhs_pkg::S_EXP;
      mhs_pkg::S_EXP:    state_d = mhs_pkg::S_INTERP;
      mhs_pkg::S_INTERP: state_d = mhs_pkg::S_INTERP;
      mhs_pkg::S_ACCMUL: state_d = mhs_pkg::S_DECIDE;
      mhs_pkg::S_DECIDE: state_d = mhs_pkg::S_HREAD;
      mhs_pkg::S_HREAD:  state_d = mhs_pkg::S_HWRITE;
      mhs_pkg::S_HWRITE: begin
        if (!out_busy) begin
          state_d = mhs_pkg::S_IDLE;
        end
      end
      default:           state_d = mhs_pkg::S_IDLE;
    endcase
    // A finished mixture term moves on to the next term or ends the evaluation.
    if (term_done) begin
      if (!comp_q) begin
        state_d = mhs_pkg::S_SQ;
      end else if (load_q) begin
        state_d = mhs_pkg::S_IDLE;
      end else begin
        state_d = mhs_pkg::S_ACCMUL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mhs_pkg::S_SQ;
      scale_q     <= mhs_pkg::SCALE_RESET;
      pos_q       <= mhs_pkg::START_RESET;
      x_q         <= mhs_pkg::START_RESET;
      cd_q        <= '0;
      dens_q      <= '0;
      comp_q      <= 1'b0;
      load_q      <= 1'b1;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        if (cfg_index_i == mhs_pkg::REG_START) begin
          pos_q  <= cfg_data_i;
          x_q    <= cfg_data_i;
          dens_q <= '0;
          comp_q <= 1'b0;
          load_q <= 1'b1;
        end else if (cfg_index_i == mhs_pkg::REG_SCALE) begin
          scale_q <= cfg_data_i;
        end
      end
      if (state_q == mhs_pkg::S_PROP) begin
        x_q    <= prop_sat;
        dens_q <= '0;
        comp_q <= 1'b0;
        load_q <= 1'b0;
      end
      if (term_done) begin
        dens_q <= dens_next;
        comp_q <= !comp_q;
        if (comp_q && load_q) begin
          cd_q <= dens_next;
        end
      end
      if ((state_q == mhs_pkg::S_DECIDE) && accept_prop) begin
        pos_q <= x_q;
        cd_q  <= dens_q;
      end
      if (hist_we) begin
        valid_q[bin_idx] <= 1'b1;
        out_valid_q      <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    if (in_acc) begin
      nd_q <= normal_draw_i;
      u_q  <= uniform_draw_i;
    end
    if (state_q == mhs_pkg::S_EXP) begin
      f_q <= yv[15:0];
      n_q <= yv[20:16];
    end
    if (state_q == mhs_pkg::S_DECIDE) begin
      acc_q <= accept_prop;
    end
    if (hist_we) begin
      out_pos_q <= pos_q;
      out_acc_q <= acc_q;
      out_bin_q <= 8'(bin_idx);
      out_cnt_q <= cnt_ext[19:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign new_position_o = out_pos_q;
  assign accepted_o     = out_acc_q;
  assign bin_index_o    = out_bin_q;
  assign bin_count_o    = out_cnt_q;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for metropolis_hastings_sampler_unit: random-walk chain,
// mixture density, accept decision and histogram counts are predicted and compared.
// Depends on mhs_pkg and the sampler RTL.
module testbench;

  localparam int          NBINS      = 64;
  localparam int unsigned COUNT_MAX  = (1 << 20) - 1;
  localparam logic [1:0]  REG_NONE   = 2'd3;
  localparam int          STALL_LIMIT = 6000;

  typedef struct packed {
    logic [15:0] normal;
    logic [15:0] uniform;
  } draw_t;

  typedef struct packed {
    logic [15:0] position;
    logic        taken;
    logic [7:0]  bin;
    logic [19:0] count;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] normal_draw_i = '0;
  logic [15:0] uniform_draw_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] new_position_o;
  logic        accepted_o;
  logic [7:0]  bin_index_o;
  logic [19:0] bin_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  metropolis_hastings_sampler_unit i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Chain state mirrored from the block.
  logic signed [15:0] start_pos;
  logic [15:0]        step_scale;
  logic signed [15:0] chain_pos;
  int unsigned        chain_dens;
  int unsigned        bin_counts[NBINS];
  int unsigned        exp2_tab[17] = '{65536, 62758, 60097, 57549, 55109, 52773, 50535,
                                       48393, 46341, 44376, 42495, 40693, 38968, 37316,
                                       35734, 34219, 32768};

  draw_t   pending_draws[$];
  sample_t expected_samples[$];
  int      mismatches = 0;
  bit      idle_en = 1'b1;
  bit      hold_req = 1'b0;

  function automatic int unsigned gauss_q16(longint x, longint mean, longint tvar);
    longint      d, t, y, n;
    int unsigned f, k, r, v;
    d = x - mean;
    if (d < 0) d = -d;
    t = (d * d) / tvar;
    y = (t * 94548) >> 16;
    n = y >> 16;
    f = 32'(y & 16'hFFFF);
    if (n > 16) return 0;
    k = f >> 12;
    r = f & 12'hFFF;
    v = exp2_tab[k] - (((exp2_tab[k] - exp2_tab[k + 1]) * r) >> 12);
    return v >> n;
  endfunction

  function automatic int unsigned mixture_density(longint x);
    return gauss_q16(x, -1280, 50) + gauss_q16(x, -3840, 18);
  endfunction

  function automatic void apply_reg_write(logic [1:0] idx, logic [15:0] data);
    if (idx == mhs_pkg::REG_START) begin
      start_pos  = data;
      chain_pos  = start_pos;
      chain_dens = mixture_density(start_pos);
    end else if (idx == mhs_pkg::REG_SCALE) begin
      step_scale = data;
    end
  endfunction

  function automatic sample_t advance_chain(draw_t d);
    longint      prod, prop;
    int unsigned pd;
    bit          take;
    int          p, rnd, bin;
    sample_t     s;
    prod = longint'(step_scale) * longint'($signed(d.normal));
    prop = longint'(chain_pos) + (prod >>> 12);
    if (prop > 32767) prop = 32767;
    if (prop < -32768) prop = -32768;
    pd = mixture_density(prop);
    take = (longint'(pd) << 16) >= longint'(d.uniform) * longint'(chain_dens);
    if (take) begin
      chain_pos  = 16'(prop);
      chain_dens = pd;
    end
    p = chain_pos;
    rnd = (p >= 0) ? ((p + 128) >>> 8) : -((-p + 128) >>> 8);
    bin = rnd + NBINS / 2;
    if (bin < 0) bin = 0;
    if (bin > NBINS - 1) bin = NBINS - 1;
    if (bin_counts[bin] < COUNT_MAX) bin_counts[bin]++;
    s.position = chain_pos;
    s.taken    = take;
    s.bin      = 8'(bin);
    s.count    = 20'(bin_counts[bin]);
    return s;
  endfunction

  // Request driver: holds a stalled request steady, inserts random idle bursts.
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_samples.push_back(advance_chain(pending_draws.pop_front()));
    end
    if (!(in_valid_i && in_stall_o)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_draws.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 7);
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        normal_draw_i <= pending_draws[0].normal;
        uniform_draw_i <= pending_draws[0].uniform;
      end
    end
  end

  // Result monitor with random stall bursts and one long hold-off.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    sample_t got, want;
    if (out_valid_o && !out_stall_i) begin
      got = '{new_position_o, accepted_o, bin_index_o, bin_count_o};
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("metropolis_hastings_sampler_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg_write(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_draws.size() == 0 && expected_samples.size() == 0);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic queue_draw(logic [15:0] nd, logic [15:0] ud);
    draw_t d;
    d.normal = nd;
    d.uniform = ud;
    pending_draws.push_back(d);
  endtask

  // Mostly near-unit normal draws, now and then any 16-bit value.
  task automatic queue_random(int n);
    logic [15:0] nd;
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) nd = 16'($urandom);
      else nd = 16'($urandom_range(0, 16384)) - 16'd8192;
      queue_draw(nd, 16'($urandom));
    end
  endtask

  initial begin
    start_pos = mhs_pkg::START_RESET;
    step_scale = mhs_pkg::SCALE_RESET;
    chain_pos = mhs_pkg::START_RESET;
    chain_dens = mixture_density(mhs_pkg::START_RESET);
    foreach (bin_counts[i]) bin_counts[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, extremes of both draws.
    queue_draw(16'h8000, 16'h0000);
    queue_draw(16'h7FFF, 16'hFFFF);
    queue_draw(16'h0000, 16'h0000);
    queue_draw(16'h0001, 16'hFFFF);
    queue_draw(16'hFFFF, 16'h8000);
    drain();

    // Far right start: zero density, so every proposal is taken; saturating steps.
    write_reg(mhs_pkg::REG_START, 16'h7FFF);
    write_reg(mhs_pkg::REG_SCALE, 16'hFFFF);
    queue_draw(16'h7FFF, 16'hFFFF);
    queue_draw(16'h8000, 16'hFFFF);
    queue_draw(16'h8000, 16'h0001);
    queue_draw(16'h7FFF, 16'h0000);
    drain();

    // Far left with a frozen chain: low-edge bin clamp; a write to no register.
    write_reg(mhs_pkg::REG_START, 16'h8000);
    write_reg(mhs_pkg::REG_SCALE, 16'h0000);
    write_reg(REG_NONE, 16'h1234);
    queue_draw(16'h1234, 16'hFFFF);
    queue_draw(16'h8000, 16'h0000);
    drain();

    // Half-way positions round away from zero.
    write_reg(mhs_pkg::REG_START, -16'sd384);
    queue_draw(16'h0000, 16'hFFFF);
    queue_draw(16'h0000, 16'h0000);
    drain();
    write_reg(mhs_pkg::REG_START, 16'sd384);
    queue_draw(16'h0000, 16'hFFFF);
    queue_draw(16'h7FFF, 16'h0000);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      idle_en = (ph < 7) && (ph != 3);
      write_reg(mhs_pkg::REG_START, 16'($urandom_range(0, 8000)) - 16'd6000);
      case (ph % 4)
        0: write_reg(mhs_pkg::REG_SCALE, mhs_pkg::SCALE_RESET);
        1: write_reg(mhs_pkg::REG_SCALE, 16'($urandom_range(64, 2048)));
        2: write_reg(mhs_pkg::REG_SCALE, 16'($urandom));
        default: write_reg(mhs_pkg::REG_SCALE, 16'd256);
      endcase
      if (ph == 2) hold_req = 1'b1;
      queue_random(215);
      drain();
    end

    if (mismatches == 0) begin
      $display("metropolis_hastings_sampler_unit regression: pass");
    end else begin
      $display("metropolis_hastings_sampler_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mhs_pkg.sv
hw/rtl/mhs_ram.sv
hw/rtl/metropolis_hastings_sampler_unit.sv
dv/testbench.sv
